### hdl/scfp_pkg.sv
// shared widths, sync byte, command codes and reset speed of the serial command frame parser
package scfp_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned ClockW = 32;
  localparam int unsigned SpeedW = 16;

  localparam logic [ByteW-1:0] SYNC_BYTE = 8'hFF;

  localparam logic [ByteW-1:0] CMD_CLOCK_CLEAR = 8'h00;
  localparam logic [ByteW-1:0] CMD_SCROLL_ON   = 8'h01;
  localparam logic [ByteW-1:0] CMD_SCROLL_OFF  = 8'h02;
  localparam logic [ByteW-1:0] CMD_SPEED_LOAD  = 8'h03;
  localparam logic [ByteW-1:0] CMD_CLOCK_LOAD  = 8'h04;

  localparam logic [SpeedW-1:0] SPEED_DEFAULT = 16'd1000;

endpackage

### hdl/scfp_byte_if.sv
// valid/ready channel carrying one received serial byte per beat
interface scfp_byte_if;
  import scfp_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] byte_in;

  modport source (output valid, output byte_in, input ready);
  modport sink   (input valid, input byte_in, output ready);
endinterface

### hdl/scfp_result_if.sv
// valid/ready channel carrying one parser result per beat
interface scfp_result_if;
  import scfp_pkg::*;

  logic              valid;
  logic              ready;
  logic [ClockW-1:0] clock_value;
  logic [SpeedW-1:0] ms_per_second;
  logic              scroll_enable;
  logic              clock_written;
  logic              speed_written;

  modport source (
    output valid, output clock_value, output ms_per_second,
    output scroll_enable, output clock_written, output speed_written,
    input  ready
  );
  modport sink (
    input  valid, input clock_value, input ms_per_second,
    input  scroll_enable, input clock_written, input speed_written,
    output ready
  );
endinterface

### hdl/serial_command_frame_parser_unit.sv
// serial command frame parser: sync hunt, command decode and value loads
// an accepted byte passes from the input register into the result register once the result channel can take it
// throughput: one byte per cycle while the result channel is ready, set by the single parse-state update
// an input register and a result register part the two channels
// reset (async, active low) returns to sync hunt, clock 0, speed 1000, scroll off
module serial_command_frame_parser_unit (
  input  logic          clk_i,
  input  logic          rst_ni,
  scfp_byte_if.sink     byte_i,
  scfp_result_if.source result_o
);
  import scfp_pkg::*;

  typedef enum logic [2:0] {
    PH_HUNT = 3'd0,
    PH_CMD  = 3'd1,
    PH_SPD1 = 3'd2,
    PH_SPD2 = 3'd3,
    PH_CLK1 = 3'd4,
    PH_CLK2 = 3'd5,
    PH_CLK3 = 3'd6,
    PH_CLK4 = 3'd7
  } phase_e;

  phase_e            phase_q, phase_d;
  logic              in_v_q;
  logic [ByteW-1:0]  in_byte_q;
  logic              out_v_q;
  logic [ByteW-1:0]  spd_high_q, spd_high_d;
  logic [23:0]       clk_upper_q, clk_upper_d;
  logic [ClockW-1:0] clock_q, clock_d;
  logic [SpeedW-1:0] speed_q, speed_d;
  logic              scroll_q, scroll_d;
  logic              clk_wr_q, clk_wr_d;
  logic              spd_wr_q, spd_wr_d;
  logic              advance;

  // byte moves from the input register into the result register
  assign advance      = in_v_q && (!out_v_q || result_o.ready);
  assign byte_i.ready = !in_v_q || advance;

  always_comb begin
    phase_d     = phase_q;
    spd_high_d  = spd_high_q;
    clk_upper_d = clk_upper_q;
    clock_d     = clock_q;
    speed_d     = speed_q;
    scroll_d    = scroll_q;
    clk_wr_d    = 1'b0;
    spd_wr_d    = 1'b0;
    unique case (phase_q)
      PH_HUNT: begin
        if (in_byte_q == SYNC_BYTE) phase_d = PH_CMD;
      end
      PH_CMD: begin
        phase_d = PH_HUNT;
        unique case (in_byte_q)
          CMD_CLOCK_CLEAR: begin
            clock_d  = '0;
            clk_wr_d = 1'b1;
          end
          CMD_SCROLL_ON:  scroll_d = 1'b1;
          CMD_SCROLL_OFF: scroll_d = 1'b0;
          CMD_SPEED_LOAD: phase_d = PH_SPD1;
          CMD_CLOCK_LOAD: phase_d = PH_CLK1;
          default:        phase_d = PH_HUNT;
        endcase
      end
      PH_SPD1: begin
        spd_high_d = in_byte_q;
        phase_d    = PH_SPD2;
      end
      PH_SPD2: begin
        speed_d  = {spd_high_q, in_byte_q};
        spd_wr_d = 1'b1;
        phase_d  = PH_HUNT;
      end
      PH_CLK1: begin
        clk_upper_d = {in_byte_q, 16'h0000};
        phase_d     = PH_CLK2;
      end
      PH_CLK2: begin
        clk_upper_d = {clk_upper_q[23:16], in_byte_q, 8'h00};
        phase_d     = PH_CLK3;
      end
      PH_CLK3: begin
        clk_upper_d = {clk_upper_q[23:8], in_byte_q};
        phase_d     = PH_CLK4;
      end
      PH_CLK4: begin
        clock_d  = {clk_upper_q, in_byte_q};
        clk_wr_d = 1'b1;
        phase_d  = PH_HUNT;
      end
      default: phase_d = PH_HUNT;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q      <= 1'b0;
      out_v_q     <= 1'b0;
      phase_q     <= PH_HUNT;
      spd_high_q  <= '0;
      clk_upper_q <= '0;
      clock_q     <= '0;
      speed_q     <= SPEED_DEFAULT;
      scroll_q    <= 1'b0;
      clk_wr_q    <= 1'b0;
      spd_wr_q    <= 1'b0;
    end else begin
      if (byte_i.valid && byte_i.ready) begin
        in_v_q <= 1'b1;
      end else if (advance) begin
        in_v_q <= 1'b0;
      end
      if (advance) begin
        out_v_q     <= 1'b1;
        phase_q     <= phase_d;
        spd_high_q  <= spd_high_d;
        clk_upper_q <= clk_upper_d;
        clock_q     <= clock_d;
        speed_q     <= speed_d;
        scroll_q    <= scroll_d;
        clk_wr_q    <= clk_wr_d;
        spd_wr_q    <= spd_wr_d;
      end else if (result_o.ready) begin
        out_v_q <= 1'b0;
      end
    end
  end

  // input payload register, no reset needed
  always_ff @(posedge clk_i) begin
    if (byte_i.valid && byte_i.ready) begin
      in_byte_q <= byte_i.byte_in;
    end
  end

  // state registers only change on advance, so they double as the result
  assign result_o.valid         = out_v_q;
  assign result_o.clock_value   = clock_q;
  assign result_o.ms_per_second = speed_q;
  assign result_o.scroll_enable = scroll_q;
  assign result_o.clock_written = clk_wr_q;
  assign result_o.speed_written = spd_wr_q;

endmodule
